[src/canonical_cbor_map_parser_core_assert.svh]
// assertion macros for the canonical cbor map parser core
// used by the top level; no other dependencies
`ifndef CANONICAL_CBOR_MAP_PARSER_CORE_ASSERT_SVH
`define CANONICAL_CBOR_MAP_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbmp check failed");

// next-cycle implication, checked outside reset
`define CBMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbmp check failed");

`endif

[src/cbmp_pkg.sv]
// shared types, codes and helpers for the canonical cbor map parser
// no dependencies
package cbmp_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_TYPE      = 3'd3;
  localparam logic [2:0] ST_TOO_MANY  = 3'd4;

  localparam logic [2:0] MAJ_UINT = 3'd0;
  localparam logic [2:0] MAJ_MAP  = 3'd5;

  localparam logic [4:0] INFO_ONE_BYTE = 5'd24;
  localparam logic [4:0] INFO_TWO_BYTE = 5'd25;
  localparam logic [4:0] INFO_FOUR_BYTE = 5'd26;
  localparam logic [4:0] INFO_RESERVED = 5'd28;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] entry_key;
    logic [1:0]  value_major;
    logic [63:0] value_arg;
    logic [7:0]  span_byte;
    logic [2:0]  status;
    logic [3:0]  entry_count;
    logic        last;
  } res_t;

  // control handed along the key chain
  typedef struct packed {
    logic             shift_en;
    logic [CNT_W-1:0] live_cnt;
  } chain_ctl_t;

  // smallest value that needs the given argument length
  function automatic logic [63:0] shortest_min(input logic [4:0] info);
    logic [63:0] m;
    case (info)
      INFO_ONE_BYTE:  m = 64'd24;
      INFO_TWO_BYTE:  m = 64'h100;
      INFO_FOUR_BYTE: m = 64'h10000;
      default:        m = 64'h1_0000_0000;
    endcase
    return m;
  endfunction

endpackage

[src/cbmp_if.sv]
// valid/ready channel interfaces for message bytes and results
// depends on cbmp_pkg
interface cbmp_in_if import cbmp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cbmp_out_if import cbmp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] entry_key;
  logic [1:0]  value_major;
  logic [63:0] value_arg;
  logic [7:0]  span_byte;
  logic [2:0]  status;
  logic [3:0]  entry_count;
  logic        last;
  modport source (output valid, output kind, output entry_key, output value_major,
                  output value_arg, output span_byte, output status,
                  output entry_count, output last, input ready);
  modport sink (input valid, input kind, input entry_key, input value_major,
                input value_arg, input span_byte, input status,
                input entry_count, input last, output ready);
endinterface

[src/cbmp_key_cell.sv]
// one stage of the seen-key chain: holds a key, compares it, passes it on
// depends on cbmp_pkg
module cbmp_key_cell import cbmp_pkg::*; (
  input  logic             clk,
  input  chain_ctl_t       ctl,
  input  logic [CNT_W-1:0] pos,
  input  logic [63:0]      key_in,
  input  logic [63:0]      key_cmp,
  output logic [63:0]      key_out,
  output logic             hit
);
  logic [63:0] key_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      key_r <= key_in;
    end
  end

  // only cells holding a key from this message take part
  assign hit = (pos < ctl.live_cnt) && (key_r == key_cmp);
  assign key_out = key_r;
endmodule

[src/cbmp_key_chain.sv]
// row of key cells; newest key enters at cell 0 and moves down on each store
// depends on cbmp_pkg, cbmp_key_cell
module cbmp_key_chain import cbmp_pkg::*; (
  input  logic        clk,
  input  chain_ctl_t  ctl,
  input  logic [63:0] key_new,
  input  logic [63:0] key_cmp,
  output logic        dup
);
  logic [63:0] link [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hits;

  assign link[0] = key_new;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cbmp_key_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pos     (CNT_W'(i)),
      .key_in  (link[i]),
      .key_cmp (key_cmp),
      .key_out (link[i+1]),
      .hit     (hits[i])
    );
  end

  assign dup = |hits;
endmodule

[src/canonical_cbor_map_parser_core.sv]
// One message byte is taken per beat and checked as a canonical CBOR
// definite-length map with unsigned keys; each beat gives zero, one or two
// results (entry header, string data byte, message status). A beat that
// gives one result is accepted every cycle the output side keeps up; a beat
// that gives two holds the input while the second result
// drains from the skid slot. Duplicate keys are checked against a chain of
// MAX_ENTRIES key cells in the same cycle as the key head completes.
// depends on cbmp_pkg, cbmp_if, cbmp_key_chain, canonical_cbor_map_parser_core_assert.svh
`include "canonical_cbor_map_parser_core_assert.svh"

module canonical_cbor_map_parser_core import cbmp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cbmp_in_if.sink    in_chan,
  cbmp_out_if.source out_chan
);
  typedef enum logic [2:0] {
    PH_MAP, PH_MAP_ARG, PH_KEY, PH_KEY_ARG, PH_VAL, PH_VAL_ARG, PH_SPAN, PH_DONE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       hm_r, hm_nxt;
  logic [3:0]       left_r, left_nxt;
  logic [4:0]       info_r, info_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [63:0]      key_r, key_nxt;
  logic [63:0]      span_r, span_nxt;
  logic             disc_r, disc_nxt;

  res_t res_r, pend_r, r0, r1;
  logic out_valid_r, pend_valid_r;
  logic [1:0] n;
  logic store_en, dup, in_fire;
  chain_ctl_t chain_ctl;

  logic [7:0] b;
  logic eom;
  assign b   = in_chan.data_byte;
  assign eom = in_chan.end_of_message;

  assign in_chan.ready = !pend_valid_r && (!out_valid_r || out_chan.ready);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign chain_ctl.shift_en = in_fire && store_en;
  assign chain_ctl.live_cnt = done_r;

  cbmp_key_chain u_chain (
    .clk     (clk),
    .ctl     (chain_ctl),
    .key_new (key_r),
    .key_cmp (acc_nxt),
    .dup     (dup)
  );

  always_comb begin
    logic       err, head_done, fin;
    logic [2:0] code;
    logic [4:0] info;
    res_t       st;
    phase_nxt = phase_r; hm_nxt = hm_r; left_nxt = left_r; info_nxt = info_r;
    acc_nxt = acc_r; exp_nxt = exp_r; done_nxt = done_r; key_nxt = key_r;
    span_nxt = span_r; disc_nxt = disc_r;
    err = 1'b0; head_done = 1'b0; fin = 1'b0; code = ST_OK; store_en = 1'b0;
    info = b[4:0];
    n = 2'd0; r0 = '0; r1 = '0; st = '0;

    if (!disc_r) begin
      case (phase_r)
        PH_MAP, PH_KEY, PH_VAL: begin
          hm_nxt = b[7:5];
          if (info >= INFO_RESERVED) begin
            err = 1'b1; code = ST_MALFORMED;
          end else if (info < INFO_ONE_BYTE) begin
            acc_nxt = {59'd0, info};
            head_done = 1'b1;
          end else begin
            info_nxt = info;
            left_nxt = 4'd1 << info[1:0];
            acc_nxt = '0;
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end
        PH_MAP_ARG, PH_KEY_ARG, PH_VAL_ARG: begin
          acc_nxt = {acc_r[55:0], b};
          left_nxt = (left_r != 4'd0) ? left_r - 4'd1 : left_r;
          if (left_nxt == 4'd0) begin
            phase_nxt = phase_t'(phase_r - 3'd1);
            if (acc_nxt < shortest_min(info_r)) begin
              err = 1'b1; code = ST_MALFORMED;
            end else begin
              head_done = 1'b1;
            end
          end
        end
        PH_SPAN: begin
          r0 = '{kind: KIND_DATA, entry_key: key_r, value_major: hm_r[1:0],
                 value_arg: acc_r, span_byte: b, default: '0};
          n = 2'd1;
          span_nxt = (span_r != 64'd0) ? span_r - 64'd1 : span_r;
          if (span_nxt == 64'd0) fin = 1'b1;
        end
        default: begin
          err = 1'b1; code = ST_MALFORMED;
        end
      endcase

      if (head_done) begin
        case (phase_nxt)
          PH_MAP: begin
            if (hm_nxt != MAJ_MAP) begin
              err = 1'b1; code = ST_TYPE;
            end else if (acc_nxt > 64'(MAX_ENTRIES)) begin
              err = 1'b1; code = ST_TOO_MANY;
            end else begin
              exp_nxt = CNT_W'(acc_nxt);
              done_nxt = '0;
              phase_nxt = (acc_nxt == 64'd0) ? PH_DONE : PH_KEY;
            end
          end
          PH_KEY: begin
            if (hm_nxt != MAJ_UINT) begin
              err = 1'b1; code = ST_TYPE;
            end else if (dup) begin
              err = 1'b1; code = ST_MALFORMED;
            end else begin
              key_nxt = acc_nxt;
              phase_nxt = PH_VAL;
            end
          end
          default: begin
            if (hm_nxt > 3'd3) begin
              err = 1'b1; code = ST_TYPE;
            end else begin
              store_en = (done_r < CNT_W'(MAX_ENTRIES));
              r0 = '{kind: KIND_HEADER, entry_key: key_r, value_major: hm_nxt[1:0],
                     value_arg: acc_nxt, default: '0};
              n = 2'd1;
              if (hm_nxt < 3'd2 || acc_nxt == 64'd0) begin
                fin = 1'b1;
              end else begin
                span_nxt = acc_nxt;
                phase_nxt = PH_SPAN;
              end
            end
          end
        endcase
      end

      if (fin) begin
        done_nxt = done_r + CNT_W'(1);
        phase_nxt = (done_nxt >= exp_r) ? PH_DONE : PH_KEY;
      end

      st.kind = KIND_STATUS;
      st.entry_count = 4'(done_nxt);
      st.last = eom;
      if (err) begin
        st.status = code;
        r0 = st;
        n = 2'd1;
        if (!eom) disc_nxt = 1'b1;
      end else if (eom) begin
        st.status = (phase_nxt == PH_DONE) ? ST_OK : ST_TRUNC;
        if (n == 2'd0) begin
          r0 = st;
        end else begin
          r1 = st;
        end
        n = n + 2'd1;
      end
    end

    // end of message restarts everything but the key chain
    if (eom) begin
      phase_nxt = PH_MAP; hm_nxt = '0; left_nxt = '0; info_nxt = '0; acc_nxt = '0;
      exp_nxt = '0; done_nxt = '0; key_nxt = '0; span_nxt = '0; disc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAP; hm_r <= '0; left_r <= '0; info_r <= '0; acc_r <= '0;
      exp_r <= '0; done_r <= '0; key_r <= '0; span_r <= '0; disc_r <= 1'b0;
      out_valid_r <= 1'b0; pend_valid_r <= 1'b0;
    end else begin
      if (pend_valid_r && (!out_valid_r || out_chan.ready)) begin
        res_r <= pend_r;
        out_valid_r <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        if (in_fire) begin
          phase_r <= phase_nxt; hm_r <= hm_nxt; left_r <= left_nxt; info_r <= info_nxt;
          acc_r <= acc_nxt; exp_r <= exp_nxt; done_r <= done_nxt; key_r <= key_nxt;
          span_r <= span_nxt; disc_r <= disc_nxt;
          if (n != 2'd0) res_r <= r0;
          if (n == 2'd2) begin
            pend_r <= r1;
            pend_valid_r <= 1'b1;
          end
        end
        if (in_fire && n != 2'd0) out_valid_r <= 1'b1;
        else if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = res_r.kind;
  assign out_chan.entry_key   = res_r.entry_key;
  assign out_chan.value_major = res_r.value_major;
  assign out_chan.value_arg   = res_r.value_arg;
  assign out_chan.span_byte   = res_r.span_byte;
  assign out_chan.status      = res_r.status;
  assign out_chan.entry_count = res_r.entry_count;
  assign out_chan.last        = res_r.last;

  `CBMP_ASSERT_IMPL(a_pend_behind_out, pend_valid_r, out_valid_r)
  `CBMP_ASSERT_NEXT(a_eom_restarts, in_fire && eom, phase_r == PH_MAP && !disc_r)
  `CBMP_ASSERT_NEXT(a_discard_silent, in_fire && disc_r, !pend_valid_r)
  `CBMP_ASSERT_IMPL(a_count_bound, 1'b1, done_r <= exp_r)
endmodule
